// ----- hdl/hdc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants
// Operation codes, register indexes and the structs passed between the
// heap controller, its engine and the top level.
// ----------------------------------------------------------------------------
package hdc_pkg;

    // Field widths fixed by the item format
    localparam int VALUE_W   = 31;
    localparam int OP_W      = 2;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 1;

    // Operation codes; the spare code behaves as a read
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEVELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LEVELS  = 1'b1;

    // Register reset values
    localparam logic [LEVEL_W-1:0] TOTAL_LEVELS_RST = 4'd10;
    localparam logic [LEVEL_W-1:0] KEEP_LEVELS_RST  = 4'd1;

    typedef struct packed {
        logic [LEVEL_W-1:0] total_levels;
        logic [LEVEL_W-1:0] keep_levels;
    } cfg_t;

    typedef struct packed {
        logic               removed;
        logic [VALUE_W-1:0] slot_value;
    } result_t;

endpackage

// ----- hdl/hdc_ram.sv -----
// ----------------------------------------------------------------------------
// hdc_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hdc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hdl/hdc_engine.sv -----
// ----------------------------------------------------------------------------
// hdc_engine: heap operation sequencer
// Runs load, read and checked removal against the heap RAM. A removal walks
// down one level per cycle reading both children, keeps the path, and then
// writes the path back shifted up by one slot, one slot per cycle.
// ----------------------------------------------------------------------------
module hdc_engine import hdc_pkg::*; #(
    parameter int HEAP_LEVELS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    // command side
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        in_op,
    input  logic [HEAP_LEVELS-1:0] in_index,
    input  logic [VALUE_W-1:0]     in_value,
    // result side
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res,
    // heap RAM
    output logic                   ram_we,
    output logic [HEAP_LEVELS-1:0] ram_waddr,
    output logic [VALUE_W-1:0]     ram_wdata,
    output logic [HEAP_LEVELS-1:0] ram_raddr_a,
    input  logic [VALUE_W-1:0]     ram_rdata_a,
    output logic [HEAP_LEVELS-1:0] ram_raddr_b,
    input  logic [VALUE_W-1:0]     ram_rdata_b
);

    localparam int CW = HEAP_LEVELS + 1;              // child index, may overflow
    localparam int DW = $clog2(HEAP_LEVELS + 1);      // path length counter
    localparam int PW = (HEAP_LEVELS > 1) ? $clog2(HEAP_LEVELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_WALK,
        S_PULL,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [HEAP_LEVELS-1:0] idx_reg, idx_next;
    logic [VALUE_W-1:0]     root_val_reg, root_val_next;
    logic [HEAP_LEVELS-1:0] x_reg, x_next;
    logic [HEAP_LEVELS-1:0] cur_reg, cur_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [DW-1:0]          k_reg, k_next;
    result_t                res_reg, res_next;
    logic [VALUE_W-1:0]     val_reg [HEAP_LEVELS];
    logic [HEAP_LEVELS-1:0] dir_reg;

    logic [LEVEL_W-1:0]     lvl;
    logic [CW-1:0]          lchild, rchild, pick_c;
    logic [VALUE_W-1:0]     lv, rv, pick_v, root_v;
    logic                   pick_r;
    logic                   push_en;
    logic [HEAP_LEVELS-1:0] rd_node;
    logic [CW-1:0]          rd_lchild, rd_rchild;
    logic [CW-1:0]          cur_child;

    // Slot inside the configured heap and not slot zero
    function automatic logic slot_ok(input logic [CW-1:0] s, input logic [LEVEL_W-1:0] l);
        return (s != '0) && ((s >> l) == '0);
    endfunction

    // Effective heap height, saturated to the store size
    assign lvl = (32'(cfg.total_levels) > HEAP_LEVELS) ? LEVEL_W'(HEAP_LEVELS)
                                                       : cfg.total_levels;

    // Children of the current walk node, larger one wins, ties go right
    assign lchild = {x_reg, 1'b0};
    assign rchild = {x_reg, 1'b1};
    assign lv     = slot_ok(lchild, lvl) ? ram_rdata_a : '0;
    assign rv     = slot_ok(rchild, lvl) ? ram_rdata_b : '0;
    assign pick_r = !(lv > rv);
    assign pick_v = pick_r ? rv : lv;
    assign pick_c = {x_reg, pick_r};
    assign root_v = slot_ok({1'b0, idx_reg}, lvl) ? ram_rdata_a : '0;

    // Read addresses: root on accept, children of the next node otherwise
    always_comb begin
        rd_node = idx_reg;
        if (state_reg == S_WALK) begin
            rd_node = pick_c[HEAP_LEVELS-1:0];
        end
    end
    assign rd_lchild   = {rd_node, 1'b0};
    assign rd_rchild   = {rd_node, 1'b1};
    assign ram_raddr_a = (state_reg == S_IDLE) ? in_index : rd_lchild[HEAP_LEVELS-1:0];
    assign ram_raddr_b = rd_rchild[HEAP_LEVELS-1:0];

    assign cur_child = {cur_reg, dir_reg[k_reg[PW-1:0]]};

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and datapath control
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        root_val_next = root_val_reg;
        x_next        = x_reg;
        cur_next      = cur_reg;
        depth_next    = depth_reg;
        k_next        = k_reg;
        res_next      = res_reg;
        push_en       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg;
        ram_wdata     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next  = in_op;
                    idx_next = in_index;
                    if (in_op == OP_LOAD) begin
                        // slot zero is not part of the heap
                        ram_we              = (in_index != '0);
                        ram_waddr           = in_index;
                        ram_wdata           = in_value;
                        res_next.removed    = 1'b0;
                        res_next.slot_value = slot_ok({1'b0, in_index}, lvl) ? in_value : '0;
                        state_next          = S_DONE;
                    end else begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                root_val_next = root_v;
                x_next        = idx_reg;
                depth_next    = '0;
                if (op_reg == OP_REMOVE && root_v != '0) begin
                    state_next = S_WALK;
                end else begin
                    res_next.removed    = 1'b0;
                    res_next.slot_value = root_v;
                    state_next          = S_DONE;
                end
            end
            S_WALK: begin
                if (pick_v != '0) begin
                    // step down one level and keep the moved value
                    push_en    = 1'b1;
                    x_next     = pick_c[HEAP_LEVELS-1:0];
                    depth_next = depth_reg + 1'b1;
                end else if ((x_reg >> cfg.keep_levels) != '0) begin
                    cur_next   = idx_reg;
                    k_next     = '0;
                    state_next = S_PULL;
                end else begin
                    res_next.removed    = 1'b0;
                    res_next.slot_value = root_val_reg;
                    state_next          = S_DONE;
                end
            end
            S_PULL: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                if (k_reg != depth_reg) begin
                    ram_wdata = val_reg[k_reg[PW-1:0]];
                    cur_next  = cur_child[HEAP_LEVELS-1:0];
                    k_next    = k_reg + 1'b1;
                end else begin
                    // end slot is cleared
                    ram_wdata           = '0;
                    res_next.removed    = 1'b1;
                    res_next.slot_value = (depth_reg != '0) ? val_reg[0] : '0;
                    state_next          = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        root_val_reg <= root_val_next;
        x_reg        <= x_next;
        cur_reg      <= cur_next;
        depth_reg    <= depth_next;
        k_reg        <= k_next;
        res_reg      <= res_next;
        if (push_en) begin
            val_reg[depth_reg[PW-1:0]] <= pick_v;
            dir_reg[depth_reg[PW-1:0]] <= pick_r;
        end
    end

endmodule

// ----- hdl/heap_depth_checked_remove.sv -----
// ----------------------------------------------------------------------------
// heap_depth_checked_remove: max-heap with depth-checked removal
// Heap RAM, operation engine, configuration registers and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ channel (op, index, value); each gives exactly one
//   result on the m_ channel (removed, slot_value), in order.
//   Ops: load writes a slot, read returns a slot, try-remove checks the slot,
//   walks down the larger-child path and, if the path ends deep enough,
//   shifts the path up one slot and clears its end slot.
//   One item is worked at a time. The walk costs one cycle per level
//   (both children come from the two RAM read ports at once); the
//   write-back costs one cycle per slot on the single RAM write port.
//   The result passes from the engine through the output register to m_.
//   An output register holds a finished result while the next item is taken;
//   with both the register and the engine full, s_tready stays low.
//   Reset clears control and restores the registers (total_levels 10,
//   keep_levels 1); heap RAM content is undefined until loaded.
// ----------------------------------------------------------------------------
module heap_depth_checked_remove import hdc_pkg::*; #(
    parameter int HEAP_LEVELS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [LEVEL_W-1:0]         cfg_data,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // fields from bit 0: op, index, value, zero fill
    input  logic [((OP_W+HEAP_LEVELS+VALUE_W+7)/8)*8-1:0] s_tdata,
    // result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // fields from bit 0: removed, slot_value
    output logic [((1+VALUE_W+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((1 + VALUE_W + 7) / 8) * 8;

    cfg_t                   cfg_reg;
    logic                   res_valid, res_ready;
    result_t                res;
    logic                   out_valid_reg;
    result_t                out_data_reg;
    logic [OP_W-1:0]        in_op;
    logic [HEAP_LEVELS-1:0] in_index;
    logic [VALUE_W-1:0]     in_value;
    logic                   ram_we;
    logic [HEAP_LEVELS-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [VALUE_W-1:0]     ram_wdata, ram_rdata_a, ram_rdata_b;

    // Unpack input fields
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_index = s_tdata[OP_W+HEAP_LEVELS-1:OP_W];
    assign in_value = s_tdata[OP_W+HEAP_LEVELS+VALUE_W-1:OP_W+HEAP_LEVELS];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.total_levels <= TOTAL_LEVELS_RST;
            cfg_reg.keep_levels  <= KEEP_LEVELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TOTAL_LEVELS: cfg_reg.total_levels <= cfg_data;
                CFG_KEEP_LEVELS:  cfg_reg.keep_levels  <= cfg_data;
                default: ;
            endcase
        end
    end

    hdc_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(1 << HEAP_LEVELS)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr_a(ram_raddr_a),
        .rdata_a(ram_rdata_a),
        .raddr_b(ram_raddr_b),
        .rdata_b(ram_rdata_b)
    );

    hdc_engine #(
        .HEAP_LEVELS(HEAP_LEVELS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (in_op),
        .in_index   (in_index),
        .in_value   (in_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr_a(ram_raddr_a),
        .ram_rdata_a(ram_rdata_a),
        .ram_raddr_b(ram_raddr_b),
        .ram_rdata_b(ram_rdata_b)
    );

    // Output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_data_reg.slot_value, out_data_reg.removed});

endmodule
